>>> rtl/touch_gesture_classifier_defines.svh
// Assertion macros for the touch gesture classifier checker.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tgc_pkg.sv
// Shared types and constants of the touch gesture classifier.
// Used by every module of the block; depends on nothing.
package tgc_pkg;

  localparam int ACT_W        = 3;
  localparam int VAL_W        = 16;
  localparam int NET_W        = 24;
  localparam int SUM_BITS_DEF = 24;
  localparam int Q_DEPTH      = 2;
  localparam int QPTR_W       = $clog2(Q_DEPTH);
  localparam int QCNT_W       = $clog2(Q_DEPTH + 1);

  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = 3;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [ACT_W-1:0] ACT_X    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_Y    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BTN  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TICK = 3'd3;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RATIO_NUM = 2'd1;
  localparam logic [1:0] REG_RATIO_DEN = 2'd2;
  localparam logic [1:0] REG_QUIET     = 2'd3;

  localparam logic [15:0] THRESHOLD_RST = 16'd10;
  localparam logic [3:0]  RATIO_NUM_RST = 4'd3;
  localparam logic [3:0]  RATIO_DEN_RST = 4'd2;
  localparam logic [15:0] QUIET_RST     = 16'd300;

  typedef enum logic [2:0] {
    OP_X, OP_Y, OP_BTN, OP_TICK, OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    KIND_CLICK, KIND_SWIPE, KIND_DRAG, KIND_UNREC
  } kind_e;

  typedef enum logic [1:0] {
    DIR_LEFT, DIR_RIGHT, DIR_UP, DIR_DOWN
  } dir_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
    logic [1:0]              level;
  } op_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [3:0]  ratio_num;
    logic [3:0]  ratio_den;
    logic [15:0] quiet;
  } cfg_t;

  typedef struct packed {
    kind_e                   kind;
    dir_e                    dir;
    logic                    notify;
    logic signed [NET_W-1:0] net_x;
    logic signed [NET_W-1:0] net_y;
  } res_t;

endpackage

>>> rtl/tgc_front.sv
// Front end: decodes a raw touchpad event into an operation for the back end.
// Depends on tgc_pkg.
module tgc_front (
  input  logic [tgc_pkg::ACT_W-1:0]        action_i,
  input  logic signed [tgc_pkg::VAL_W-1:0] value_i,
  output tgc_pkg::op_t                     op_o
);
  import tgc_pkg::*;

  always_comb begin
    op_o.value = value_i;
    if (value_i == '0) begin
      op_o.level = 2'd0;
    end else if (value_i > 0 && value_i <= 3) begin
      op_o.level = value_i[1:0];
    end else begin
      op_o.level = 2'd3;
    end
    unique case (action_i)
      ACT_X:    op_o.op = OP_X;
      ACT_Y:    op_o.op = OP_Y;
      ACT_BTN:  op_o.op = OP_BTN;
      ACT_TICK: op_o.op = OP_TICK;
      default:  op_o.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/tgc_queue.sv
// Short FIFO of decoded operations between the front and back ends.
// Depends on tgc_pkg.
module tgc_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  tgc_pkg::op_t in_op_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output tgc_pkg::op_t out_op_o
);
  import tgc_pkg::*;

  op_t               mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign in_ready_o  = (count_q != QCNT_W'(Q_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_op_o    = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_op_i;
    end
  end

endmodule

>>> rtl/tgc_back.sv
// Back end: gesture state update, quiet timer, and classification of judged gestures.
// Depends on tgc_pkg.
module tgc_back #(
  parameter int SumBits = tgc_pkg::SUM_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tgc_pkg::cfg_t cfg_i,
  input  logic         op_valid_i,
  output logic         op_ready_o,
  input  tgc_pkg::op_t op_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output tgc_pkg::res_t res_o
);
  import tgc_pkg::*;

  localparam int ProdW = SumBits + 4;
  localparam int ExtW  = (SumBits > NET_W) ? SumBits : NET_W;
  localparam logic signed [SumBits-1:0] SumMax = {1'b0, {(SumBits-1){1'b1}}};
  localparam logic signed [SumBits-1:0] SumMin = {1'b1, {(SumBits-1){1'b0}}};
  localparam logic signed [ExtW-1:0]    NetMax = ExtW'((2**(NET_W-1)) - 1);
  localparam logic signed [ExtW-1:0]    NetMin = ~NetMax;

  logic signed [SumBits-1:0] sum_x_q, sum_y_q, rec_x_q, rec_y_q;
  logic signed [SumBits-1:0] sum_x_d, sum_y_d, rec_x_d, rec_y_d;
  logic [1:0]                level_q, level_d;
  logic                      seen_q, seen_d, expired_q, expired_d;
  logic [15:0]               count_q, count_d;
  logic                      emit;

  logic                      job_valid_q;
  logic signed [SumBits-1:0] job_x_q, job_y_q;
  logic                      job_seen_q;

  logic                      out_valid_q;
  res_t                      out_q, res_d;

  logic                      out_adv, job_free, pop;

  logic [SumBits-1:0]        ax, ay, thr;
  logic [3:0]                den;
  logic [ProdW-1:0]          den_ax, num_ay, den_ay, num_ax;

  function automatic logic signed [SumBits-1:0] sat_add(
    input logic signed [SumBits-1:0] a,
    input logic signed [VAL_W-1:0]   b
  );
    logic signed [SumBits:0] s;
    s = (SumBits+1)'(a) + (SumBits+1)'(b);
    if (s[SumBits] != s[SumBits-1]) begin
      return s[SumBits] ? SumMin : SumMax;
    end
    return s[SumBits-1:0];
  endfunction

  function automatic logic signed [NET_W-1:0] net_sat(input logic signed [SumBits-1:0] v);
    logic signed [ExtW-1:0] e;
    e = ExtW'(v);
    if (e > NetMax) begin
      e = NetMax;
    end else if (e < NetMin) begin
      e = NetMin;
    end
    return e[NET_W-1:0];
  endfunction

  assign out_adv     = !out_valid_q || res_ready_i;
  assign job_free    = !job_valid_q || out_adv;
  assign op_ready_o  = job_free;
  assign pop         = op_valid_i && job_free;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    rec_x_d   = rec_x_q;
    rec_y_d   = rec_y_q;
    level_d   = level_q;
    seen_d    = seen_q;
    expired_d = expired_q;
    count_d   = count_q;
    emit      = 1'b0;
    unique case (op_i.op)
      OP_X: begin
        sum_x_d = sat_add(sum_x_q, op_i.value);
        rec_x_d = sat_add(rec_x_q, op_i.value);
      end
      OP_Y: begin
        sum_y_d = sat_add(sum_y_q, op_i.value);
        rec_y_d = sat_add(rec_y_q, op_i.value);
      end
      OP_BTN: begin
        level_d = op_i.level;
        seen_d  = 1'b1;
      end
      OP_TICK: begin
        if (!expired_q) begin
          if (count_q <= 16'd1) begin
            count_d   = '0;
            expired_d = 1'b1;
          end else begin
            count_d = count_q - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (expired_d) begin
      if (rec_x_d != '0 || rec_y_d != '0 || level_d != '0) begin
        rec_x_d   = '0;
        rec_y_d   = '0;
        expired_d = 1'b0;
        count_d   = cfg_i.quiet;
      end else if (sum_x_d != '0 || sum_y_d != '0 || seen_d) begin
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      rec_x_q     <= '0;
      rec_y_q     <= '0;
      level_q     <= '0;
      seen_q      <= 1'b0;
      expired_q   <= 1'b1;
      count_q     <= '0;
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        sum_x_q   <= emit ? '0 : sum_x_d;
        sum_y_q   <= emit ? '0 : sum_y_d;
        rec_x_q   <= rec_x_d;
        rec_y_q   <= rec_y_d;
        level_q   <= level_d;
        seen_q    <= emit ? 1'b0 : seen_d;
        expired_q <= expired_d;
        count_q   <= count_d;
      end
      if (job_free) begin
        job_valid_q <= pop && emit;
      end
      if (out_adv) begin
        out_valid_q <= job_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      job_x_q    <= sum_x_d;
      job_y_q    <= sum_y_d;
      job_seen_q <= seen_d;
    end
    if (out_adv && job_valid_q) begin
      out_q <= res_d;
    end
  end

  always_comb begin
    ax     = job_x_q[SumBits-1] ? SumBits'(-job_x_q) : SumBits'(job_x_q);
    ay     = job_y_q[SumBits-1] ? SumBits'(-job_y_q) : SumBits'(job_y_q);
    thr    = SumBits'(cfg_i.threshold);
    den    = (cfg_i.ratio_den == '0) ? 4'd1 : cfg_i.ratio_den;
    den_ax = ProdW'(ax) * ProdW'(den);
    den_ay = ProdW'(ay) * ProdW'(den);
    num_ax = ProdW'(ax) * ProdW'(cfg_i.ratio_num);
    num_ay = ProdW'(ay) * ProdW'(cfg_i.ratio_num);

    res_d.kind   = KIND_UNREC;
    res_d.dir    = DIR_LEFT;
    res_d.notify = 1'b0;
    res_d.net_x  = net_sat(job_x_q);
    res_d.net_y  = net_sat(job_y_q);
    if (ax < thr && ay < thr && job_seen_q) begin
      res_d.kind = KIND_CLICK;
    end else if (ax > thr && den_ax > num_ay) begin
      res_d.kind   = job_seen_q ? KIND_DRAG : KIND_SWIPE;
      res_d.dir    = (!job_x_q[SumBits-1] && job_x_q != '0) ? DIR_RIGHT : DIR_LEFT;
      res_d.notify = !job_seen_q;
    end else if (ay > thr && den_ay > num_ax) begin
      res_d.kind   = job_seen_q ? KIND_DRAG : KIND_SWIPE;
      res_d.dir    = (!job_y_q[SumBits-1] && job_y_q != '0) ? DIR_DOWN : DIR_UP;
      res_d.notify = !job_seen_q;
    end
  end

endmodule

>>> rtl/touch_gesture_classifier.sv
// Touch gesture classifier top level: register port, front decode, queue and back end.
// Throughput is one event per cycle, set by the state update in the back end, unless output back-pressure stalls it.
// A result passes through the queue, the job register and the output register before it is valid at the output.
// Events that cause no result are absorbed at the same rate without producing output.
// Reset is asynchronous, active low: sums, button state and timer clear, the timer reads
// as expired, and the registers return to threshold 10, ratio 3/2 and 300 quiet ticks.
module touch_gesture_classifier #(
  parameter int SumBits = tgc_pkg::SUM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // event_value
  input  logic [tgc_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [tgc_pkg::S_USER_W-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // direction, net_x, net_y, zero pad
  output logic [tgc_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // gesture_kind, notify
  output logic [tgc_pkg::M_USER_W-1:0]  m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgc_pkg::APB_AW-1:0]    paddr,
  input  logic [tgc_pkg::APB_DW-1:0]    pwdata,
  output logic [tgc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import tgc_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  op_t        front_op, queue_op;
  logic       queue_valid, back_ready;
  res_t       res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.ratio_num <= RATIO_NUM_RST;
      cfg_q.ratio_den <= RATIO_DEN_RST;
      cfg_q.quiet     <= QUIET_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg_q.threshold <= pwdata[15:0];
        REG_RATIO_NUM: cfg_q.ratio_num <= pwdata[3:0];
        REG_RATIO_DEN: cfg_q.ratio_den <= pwdata[3:0];
        REG_QUIET:     cfg_q.quiet     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = APB_DW'(cfg_q.threshold);
      REG_RATIO_NUM: prdata = APB_DW'(cfg_q.ratio_num);
      REG_RATIO_DEN: prdata = APB_DW'(cfg_q.ratio_den);
      REG_QUIET:     prdata = APB_DW'(cfg_q.quiet);
      default:       prdata = '0;
    endcase
  end

  tgc_front u_front (
    .action_i (s_axis_tuser[ACT_W-1:0]),
    .value_i  (s_axis_tdata[VAL_W-1:0]),
    .op_o     (front_op)
  );

  tgc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (front_op),
    .out_valid_o (queue_valid),
    .out_ready_i (back_ready),
    .out_op_o    (queue_op)
  );

  tgc_back #(
    .SumBits (SumBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (queue_valid),
    .op_ready_o  (back_ready),
    .op_i        (queue_op),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = {res.notify, res.kind};
  assign m_axis_tdata = {{(M_DATA_W - 2 - 2 * NET_W){1'b0}}, res.net_y, res.net_x, res.dir};

endmodule

>>> rtl/tgc_checker.sv
// Port-level checker for the touch gesture classifier, bound to the top level.
// Depends on tgc_pkg and touch_gesture_classifier_defines.svh.
`include "touch_gesture_classifier_defines.svh"

module tgc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tgc_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic [tgc_pkg::M_USER_W-1:0]  m_axis_tuser
);
  import tgc_pkg::*;

  logic [M_DATA_W+M_USER_W-1:0] out_word;
  logic [1:0]                   out_kind, out_dir;
  logic                         out_notify, stall, is_swipe, no_motion;

  assign out_word   = {m_axis_tuser, m_axis_tdata};
  assign out_kind   = m_axis_tuser[1:0];
  assign out_notify = m_axis_tuser[2];
  assign out_dir    = m_axis_tdata[1:0];
  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign is_swipe   = (out_kind == KIND_SWIPE);
  assign no_motion  = (out_kind == KIND_CLICK) || (out_kind == KIND_UNREC);

  `TGC_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(out_word), "held result changed")
  `TGC_ASSERT_IMPLY(a_notify_swipe, m_axis_tvalid, out_notify == is_swipe, "notify mismatch")
  `TGC_ASSERT_IMPLY(a_no_dir, m_axis_tvalid && no_motion, out_dir == DIR_LEFT, "direction set")
  `TGC_ASSERT_IMPLY(a_backpressure, !s_axis_tready, $past(stall), "input stalled alone")

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (.*);

>>> sim/tb_touch_gesture_classifier.sv
// Self-checking testbench for the touch gesture classifier: event stream in, gestures out.
// Holds its own model of the classifier and compares every gesture field by field.
// Depends on tgc_pkg and the touch_gesture_classifier RTL only.
module tb_touch_gesture_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import tgc_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          SETTLE_CYCLES = 8;
  localparam longint      CYCLE_LIMIT   = 3_000_000;
  localparam int          RANDOM_EVENTS = 250;
  localparam int          SAT_REPEAT    = 260;
  localparam logic [2:0]  ACT_SPARE     = 3'd7;
  localparam longint      SUM_TOP       = (longint'(1) <<< (SUM_BITS_DEF - 1)) - 1;
  localparam longint      NET_TOP       = (longint'(1) <<< (NET_W - 1)) - 1;
  localparam res_t        NO_GESTURE    = '0;

  typedef struct packed {
    logic [2:0]  act;
    logic [15:0] val;
    bit          typed;
    res_t        want;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // event_value
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  // action
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // direction, net_x, net_y, zero pad
  logic [M_DATA_W-1:0] m_axis_tdata;
  // gesture_kind, notify
  logic [M_USER_W-1:0] m_axis_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  touch_gesture_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  cfg_t        cfg = '{THRESHOLD_RST, RATIO_NUM_RST, RATIO_DEN_RST, QUIET_RST};
  longint      total_x = 0;
  longint      total_y = 0;
  longint      fresh_x = 0;
  longint      fresh_y = 0;
  logic [1:0]  btn_level = 2'd0;
  bit          btn_seen = 1'b0;
  bit          timer_done = 1'b1;
  int unsigned timer_left = 0;

  res_t   pending_gestures[$];
  int     errors = 0;
  int     events_sent = 0;
  int     settings_used = 0;
  int     kind_tally[4] = '{0, 0, 0, 0};
  longint cycles = 0;
  bit     steady = 1'b0;

  // Quiet time is one tick throughout.
  script_row_t directed_script[26] = '{
    '{ACT_BTN,   16'h0000, 1'b1, '{KIND_CLICK, DIR_LEFT, 1'b0, 24'sd0, 24'sd0}},
    '{OP_NONE,   16'h1234, 1'b0, NO_GESTURE},
    '{ACT_SPARE, 16'h7FFF, 1'b0, NO_GESTURE},
    '{ACT_X,     16'h7FFF, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b1, '{KIND_SWIPE, DIR_RIGHT, 1'b1, 24'sd32767, 24'sd0}},
    '{ACT_Y,     16'h8000, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'hFFFF, 1'b1, '{KIND_SWIPE, DIR_UP, 1'b1, 24'sd0, -24'sd32768}},
    '{ACT_BTN,   16'h0001, 1'b0, NO_GESTURE},
    '{ACT_X,     16'hFF9C, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b0, NO_GESTURE},
    '{ACT_BTN,   16'h0000, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b1, '{KIND_DRAG, DIR_LEFT, 1'b0, -24'sd100, 24'sd0}},
    '{ACT_X,     16'h000F, 1'b0, NO_GESTURE},
    '{ACT_Y,     16'h000A, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b1, '{KIND_UNREC, DIR_LEFT, 1'b0, 24'sd15, 24'sd10}},
    '{ACT_BTN,   16'h0002, 1'b0, NO_GESTURE},
    '{ACT_BTN,   16'hFFFF, 1'b0, NO_GESTURE},
    '{ACT_BTN,   16'h0004, 1'b0, NO_GESTURE},
    '{ACT_BTN,   16'h0003, 1'b0, NO_GESTURE},
    '{ACT_BTN,   16'h0000, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b1, '{KIND_CLICK, DIR_LEFT, 1'b0, 24'sd0, 24'sd0}},
    '{ACT_Y,     16'h0032, 1'b0, NO_GESTURE},
    '{ACT_X,     16'hFFEC, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b0, NO_GESTURE},
    '{ACT_TICK,  16'h0000, 1'b1, '{KIND_SWIPE, DIR_DOWN, 1'b1, -24'sd20, 24'sd50}}
  };

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > SUM_TOP) return SUM_TOP;
    if (s < -SUM_TOP - 1) return -SUM_TOP - 1;
    return s;
  endfunction

  function automatic logic signed [NET_W-1:0] net_of(input longint v);
    longint c;
    c = (v > NET_TOP) ? NET_TOP : ((v < -NET_TOP - 1) ? -NET_TOP - 1 : v);
    return c[NET_W-1:0];
  endfunction

  // Advances the gesture state by one event; returns 1 when the event closes a gesture.
  function automatic bit classify_event(input logic [2:0] act, input logic [15:0] raw,
                                        output res_t r);
    longint v, ax, ay, thr, num, den;
    v = longint'($signed(raw));
    r = NO_GESTURE;
    case (act)
      ACT_X: begin
        total_x = sat_sum(total_x, v);
        fresh_x = sat_sum(fresh_x, v);
      end
      ACT_Y: begin
        total_y = sat_sum(total_y, v);
        fresh_y = sat_sum(fresh_y, v);
      end
      ACT_BTN: begin
        if (v == 0) btn_level = 2'd0;
        else if (v >= 1 && v <= 3) btn_level = raw[1:0];
        else btn_level = 2'd3;
        btn_seen = 1'b1;
      end
      ACT_TICK: begin
        if (!timer_done) begin
          if (timer_left <= 1) begin
            timer_left = 0;
            timer_done = 1'b1;
          end else begin
            timer_left--;
          end
        end
      end
      default: ;
    endcase
    if (!timer_done) return 1'b0;
    if (fresh_x != 0 || fresh_y != 0 || btn_level != 2'd0) begin
      fresh_x = 0;
      fresh_y = 0;
      timer_done = 1'b0;
      timer_left = 32'(cfg.quiet);
      return 1'b0;
    end
    if (total_x == 0 && total_y == 0 && !btn_seen) return 1'b0;
    ax = (total_x < 0) ? -total_x : total_x;
    ay = (total_y < 0) ? -total_y : total_y;
    thr = longint'(cfg.threshold);
    num = longint'(cfg.ratio_num);
    den = (cfg.ratio_den == 4'd0) ? 1 : longint'(cfg.ratio_den);
    r.kind = KIND_UNREC;
    r.dir = DIR_LEFT;
    r.notify = 1'b0;
    if (ax < thr && ay < thr && btn_seen) begin
      r.kind = KIND_CLICK;
    end else if (ax > thr && den * ax > num * ay) begin
      r.kind = btn_seen ? KIND_DRAG : KIND_SWIPE;
      r.dir = (total_x > 0) ? DIR_RIGHT : DIR_LEFT;
      r.notify = !btn_seen;
    end else if (ay > thr && den * ay > num * ax) begin
      r.kind = btn_seen ? KIND_DRAG : KIND_SWIPE;
      r.dir = (total_y > 0) ? DIR_DOWN : DIR_UP;
      r.notify = !btn_seen;
    end
    r.net_x = net_of(total_x);
    r.net_y = net_of(total_y);
    total_x = 0;
    total_y = 0;
    btn_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_THRESHOLD: return {16'b0, cfg.threshold};
      REG_RATIO_NUM: return {28'b0, cfg.ratio_num};
      REG_RATIO_DEN: return {28'b0, cfg.ratio_den};
      default:       return {16'b0, cfg.quiet};
    endcase
  endfunction

  function automatic logic [15:0] motion_amount();
    int unsigned lim, amount;
    lim = (cfg.threshold > 16'd20000) ? 32767 : cfg.threshold + cfg.threshold / 2 + 4;
    if ($urandom_range(9) == 0) return 16'($urandom);
    amount = $urandom_range(lim);
    return $urandom_range(1) ? 16'(-amount) : 16'(amount);
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_event(input logic [2:0] act, input logic [15:0] val,
                            input bit typed = 1'b0, input res_t want = '0);
    res_t r;
    while (!steady && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    if (classify_event(act, val, r) && !typed) pending_gestures.push_back(r);
    if (typed) pending_gestures.push_back(want);
    events_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] rd;
    apb_access(idx, 1'b0, 32'd0, rd);
    if (rd !== reg_value(idx)) begin
      $error("register %0d: expected %0h, got %0h", idx, reg_value(idx), rd);
      errors++;
    end
  endtask

  // Upper bits of a write may carry junk that the register must drop.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] wdata);
    logic [31:0] rd;
    apb_access(idx, 1'b1, wdata, rd);
    case (idx)
      REG_THRESHOLD: cfg.threshold = wdata[15:0];
      REG_RATIO_NUM: cfg.ratio_num = wdata[3:0];
      REG_RATIO_DEN: cfg.ratio_den = wdata[3:0];
      default:       cfg.quiet = wdata[15:0];
    endcase
    check_reg(idx);
  endtask

  task automatic apply_settings(input cfg_t s);
    cfg_write(REG_THRESHOLD, {16'($urandom), s.threshold});
    cfg_write(REG_RATIO_NUM, {28'($urandom), s.ratio_num});
    cfg_write(REG_RATIO_DEN, {28'($urandom), s.ratio_den});
    cfg_write(REG_QUIET, {16'($urandom), s.quiet});
    settings_used++;
  endtask

  // Releases the button if held, then ticks until the open gesture has been judged.
  task automatic finish_gesture();
    if (btn_level != 2'd0) send_event(ACT_BTN, 16'h0000);
    while (!timer_done || total_x != 0 || total_y != 0 || btn_seen)
      send_event(ACT_TICK, 16'($urandom));
  endtask

  task automatic quiet_ticks_out();
    int unsigned span, n;
    span = (cfg.quiet == 16'd0) ? 1 : cfg.quiet;
    n = ($urandom_range(99) < 75) ? 2 * span + 1 : $urandom_range(2 * span);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send_event(3'($urandom_range(ACT_SPARE, OP_NONE)), 16'($urandom));
      send_event(ACT_TICK, 16'($urandom));
    end
  endtask

  task automatic random_gestures(input int count);
    int unsigned pick, k, den_eff;
    logic [15:0] major, minor;
    bit          pressed, on_x;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(1, 4)) send_event(3'($urandom), 16'($urandom));
      end else if (pick < 22) begin
        // Exact ratio tie for the major axis, which therefore may not dominate.
        den_eff = (cfg.ratio_den == 4'd0) ? 1 : cfg.ratio_den;
        k = $urandom_range(1, 2184);
        major = 16'(cfg.ratio_num * k);
        minor = 16'(den_eff * k);
        if ($urandom_range(1)) major = -major;
        if ($urandom_range(1)) minor = -minor;
        on_x = 1'($urandom_range(1));
        send_event(on_x ? ACT_X : ACT_Y, major);
        send_event(on_x ? ACT_Y : ACT_X, minor);
      end else begin
        pressed = ($urandom_range(99) < 30);
        if (pressed) begin
          pick = $urandom_range(99);
          send_event(ACT_BTN, (pick < 50) ? 16'd1 : (pick < 70) ? 16'd2 :
                              (pick < 85) ? 16'd3 : 16'($urandom));
        end
        on_x = 1'($urandom_range(1));
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(9) == 0) send_event(OP_NONE, 16'($urandom));
          send_event(($urandom_range(99) < 70) == on_x ? ACT_X : ACT_Y, motion_amount());
        end
        if (pressed && $urandom_range(9) != 0) send_event(ACT_BTN, 16'h0000);
      end
      quiet_ticks_out();
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_touch_gesture_classifier: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : gesture_monitor
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_gestures.size() == 0) begin
        $error("gesture result with none expected: tuser %0h tdata %0h",
               m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = pending_gestures.pop_front();
        kind_tally[want.kind]++;
        if (m_axis_tuser[1:0] !== want.kind) begin
          $error("gesture_kind: expected %0d, got %0d", want.kind, m_axis_tuser[1:0]);
          errors++;
        end
        if (m_axis_tuser[2] !== want.notify) begin
          $error("notify: expected %0d, got %0d", want.notify, m_axis_tuser[2]);
          errors++;
        end
        if (m_axis_tdata[1:0] !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[25:2] !== want.net_x) begin
          $error("net_x: expected %0d, got %0d", want.net_x, $signed(m_axis_tdata[25:2]));
          errors++;
        end
        if (m_axis_tdata[49:26] !== want.net_y) begin
          $error("net_y: expected %0d, got %0d", want.net_y, $signed(m_axis_tdata[49:26]));
          errors++;
        end
        if (m_axis_tdata[M_DATA_W-1:50] !== '0) begin
          $error("pad: expected 0, got %0h", m_axis_tdata[M_DATA_W-1:50]);
          errors++;
        end
      end
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 36);
  end

  initial begin : stimulus
    cfg_t fixed_settings[5];
    cfg_t s;
    int   phase, base;
    fixed_settings = '{
      '{16'd0,     4'd1,  4'd1,  16'd0},
      '{16'hFFFF,  4'd15, 4'd15, 16'd3},
      '{16'd12,    4'd15, 4'd1,  16'd2},
      '{16'd20,    4'd1,  4'd15, 16'd1},
      '{16'd30,    4'd3,  4'd0,  16'd4}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    for (int i = 0; i < 4; i++) check_reg(2'(i));

    cfg_write(REG_QUIET, 32'd1);
    foreach (directed_script[i])
      send_event(directed_script[i].act, directed_script[i].val,
                 directed_script[i].typed, directed_script[i].want);
    settle();

    phase = 0;
    base = events_sent;
    while (events_sent - base < RANDOM_EVENTS) begin
      if (phase < 5) begin
        s = fixed_settings[phase];
      end else begin
        s.threshold = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(200));
        s.ratio_num = 4'($urandom);
        s.ratio_den = 4'($urandom);
        s.quiet = 16'($urandom_range(6));
      end
      steady = (phase == 1);
      apply_settings(s);
      random_gestures(5);
      finish_gesture();
      settle();
      phase++;
    end
    steady = 1'b0;

    // Long motion runs drive the x sum to its upper limit and the y sum to its lower one.
    apply_settings('{16'($urandom_range(200)), 4'($urandom), 4'($urandom), 16'd1});
    repeat (SAT_REPEAT) send_event(ACT_X, 16'h7FFF);
    repeat (SAT_REPEAT) send_event(ACT_Y, 16'h8000);
    finish_gesture();
    settle();

    cfg_write(REG_QUIET, 32'hFFFF_FFFF);
    apply_settings('{16'($urandom_range(200)), 4'($urandom_range(1, 15)),
                     4'($urandom_range(1, 15)), 16'd20});
    send_event(ACT_X, motion_amount());
    finish_gesture();
    settle();

    $display("Sent %0d events under %0d register settings, with saturated sums and a long",
             events_sent, settings_used + 1);
    $display("quiet count; gestures checked: click %0d, swipe %0d, drag %0d, unrecognized %0d",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
    if (errors == 0 && pending_gestures.size() == 0) begin
      $display("tb_touch_gesture_classifier: PASS");
    end else begin
      $display("tb_touch_gesture_classifier: FAIL");
    end
    $finish;
  end

endmodule
